// ----- hw/rtl/thp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thp_pkg
// Shared widths, constants and types of the sensor compensation pipeline.
// ----------------------------------------------------------------------------
package thp_pkg;

  // configuration port
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HUM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_TRIM   = 3'd4;

  // field widths
  localparam int RAWT_W  = 20;
  localparam int RAWP_W  = 20;
  localparam int RAWH_W  = 16;
  localparam int TF_W    = 24;
  localparam int TC_W    = 19;
  localparam int PRESS_W = 32;
  localparam int HUM_W   = 17;

  // divider operands: signed dividend/divisor and their magnitudes
  localparam int NUM_W     = 76;
  localparam int DEN_W     = 40;
  localparam int NMAG_W    = 75;
  localparam int DMAG_W    = 40;
  localparam int DIV_STEPS = NMAG_W;

  // formula constants
  localparam int     TC_RND       = 128;
  localparam int     PRESS_TF_OFS = 128000;
  localparam int     PDIFF_BASE   = 1048576;
  localparam int     NUM_SCALE    = 3125;
  localparam longint DEN_BIAS     = 64'sd140737488355328;
  localparam int     HUM_TF_OFS   = 76800;
  localparam int     HUM_RND_A    = 16384;
  localparam int     HUM_C_OFS    = 32768;
  localparam int     HUM_G_OFS    = 2097152;
  localparam int     HUM_RND_K    = 8192;
  localparam int     HUM_MAX      = 419430400;

  // humidity trim words
  typedef struct packed {
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
    logic signed [7:0]  h6;
  } hum_cal_t;

  // per-transaction values that ride along the pressure path
  typedef struct packed {
    logic signed [TF_W-1:0] tf;
    logic signed [TC_W-1:0] tc;
    logic [RAWH_W-1:0]      adc_h;
    logic                   dz;
  } side_t;

endpackage
`default_nettype wire

// ----- hw/rtl/thp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thp_div
// Pipelined signed divider, truncating toward zero. One quotient bit per
// stage (restoring), sideband and valid travel with each transaction.
// ----------------------------------------------------------------------------
module thp_div import thp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_vld_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic signed [DEN_W-1:0] den_i,
  input  wire side_t                   side_i,
  output logic                         out_vld_o,
  output logic [NMAG_W-1:0]            quo_mag_o,
  output logic                         quo_neg_o,
  output side_t                        side_o
);

  localparam int AC_W = NMAG_W + DMAG_W;

  logic [DIV_STEPS:0] vld_q;
  logic [AC_W-1:0]    ac_q   [DIV_STEPS+1];
  logic [DMAG_W-1:0]  dmag_q [DIV_STEPS+1];
  logic [DIV_STEPS:0] neg_q;
  side_t              side_q [DIV_STEPS+1];

  logic signed [NUM_W-1:0] nabs;
  logic signed [DEN_W-1:0] dabs;

  // entry: operand magnitudes and quotient sign
  always_comb begin
    nabs = num_i[NUM_W-1] ? -num_i : num_i;
    dabs = den_i[DEN_W-1] ? -den_i : den_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ac_q[0]   <= {{DMAG_W{1'b0}}, nabs[NMAG_W-1:0]};
    dmag_q[0] <= dabs[DMAG_W-1:0];
    neg_q[0]  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    side_q[0] <= side_i;
  end

  // one shift / compare / subtract per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [DMAG_W:0]   upper;
    logic [DMAG_W:0]   diff;
    logic [AC_W-1:0]   ac_d;

    always_comb begin
      upper = ac_q[i][AC_W-1:NMAG_W-1];
      diff  = upper - {1'b0, dmag_q[i]};
      if (!diff[DMAG_W]) begin
        ac_d = {diff[DMAG_W-1:0], ac_q[i][NMAG_W-2:0], 1'b1};
      end else begin
        ac_d = {upper[DMAG_W-1:0], ac_q[i][NMAG_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      ac_q[i+1]   <= ac_d;
      dmag_q[i+1] <= dmag_q[i];
      neg_q[i+1]  <= neg_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  assign out_vld_o = vld_q[DIV_STEPS];
  assign quo_mag_o = ac_q[DIV_STEPS][NMAG_W-1:0];
  assign quo_neg_o = neg_q[DIV_STEPS];
  assign side_o    = side_q[DIV_STEPS];

endmodule
`default_nettype wire

// ----- hw/rtl/thp_hum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thp_hum
// Humidity compensation datapath, 32-bit wrapping arithmetic, eight
// register stages, one transaction per cycle. Valid is tracked by the caller.
// ----------------------------------------------------------------------------
module thp_hum import thp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic signed [TF_W-1:0] tf_i,
  input  wire logic [RAWH_W-1:0]      adc_h_i,
  input  wire hum_cal_t               cal_i,
  output logic [HUM_W-1:0]            hum_o
);

  logic [31:0] h1_mh5_q, h1_mh6_q, h1_mh3_q;
  logic [RAWH_W-1:0] h1_adc_q;
  logic [31:0] h2_a_q, h2_b_q, h2_c_q;
  logic [31:0] h3_bc_q, h3_a_q;
  logic [31:0] h4_gh2_q, h4_a_q;
  logic [31:0] h5_v_q;
  logic [31:0] h6_ww_q, h6_v_q;
  logic [31:0] h7_x_q, h7_v_q;
  logic [HUM_W-1:0] h8_hum_q;

  logic [31:0] v, a_d, b_d, c_d, g, k, w, x_d, v3;
  logic [HUM_W-1:0] hum_d;

  always_comb begin
    v   = 32'(tf_i) - 32'(HUM_TF_OFS);
    a_d = 32'($signed({2'b00, h1_adc_q, 14'b0} - (32'(cal_i.h4) << 20)
                      - h1_mh5_q + 32'(HUM_RND_A)) >>> 15);
    b_d = 32'($signed(h1_mh6_q) >>> 10);
    c_d = 32'($signed(h1_mh3_q) >>> 11) + 32'(HUM_C_OFS);
    g   = 32'($signed(h3_bc_q) >>> 10) + 32'(HUM_G_OFS);
    k   = 32'($signed(h4_gh2_q + 32'(HUM_RND_K)) >>> 14);
    w   = 32'($signed(h5_v_q) >>> 15);
    x_d = 32'($signed(h6_ww_q) >>> 7) * {24'b0, cal_i.h1};
    v3  = h7_v_q - 32'($signed(h7_x_q) >>> 4);
    // clamp to 0..100 %RH before dropping the fraction bits
    if (v3[31]) begin
      hum_d = '0;
    end else if (v3 > 32'(HUM_MAX)) begin
      hum_d = HUM_W'(HUM_MAX >> 12);
    end else begin
      hum_d = v3[HUM_W+11:12];
    end
  end

  always_ff @(posedge clk_i) begin
    // products with the temperature offset
    h1_mh5_q <= 32'(cal_i.h5) * v;
    h1_mh6_q <= v * 32'(cal_i.h6);
    h1_mh3_q <= v * {24'b0, cal_i.h3};
    h1_adc_q <= adc_h_i;
    // offset and scale terms
    h2_a_q <= a_d;
    h2_b_q <= b_d;
    h2_c_q <= c_d;
    // gain chain
    h3_bc_q  <= h2_b_q * h2_c_q;
    h3_a_q   <= h2_a_q;
    h4_gh2_q <= g * 32'(cal_i.h2);
    h4_a_q   <= h3_a_q;
    h5_v_q   <= h4_a_q * k;
    // quadratic correction
    h6_ww_q  <= w * w;
    h6_v_q   <= h5_v_q;
    h7_x_q   <= x_d;
    h7_v_q   <= h6_v_q;
    h8_hum_q <= hum_d;
  end

  assign hum_o = h8_hum_q;

endmodule
`default_nettype wire

// ----- hw/rtl/thp_sensor_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thp_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings
// against factory trim words held in configuration registers.
//
//   channel   signals                                       handshake
//   input     raw_temperature_i raw_pressure_i              start & !busy
//             raw_humidity_i
//   result    fine_temperature_o temperature_centi_o        done_o, 1 cycle
//             pressure_q24_8_o humidity_q22_10_o
//             pressure_divisor_zero_o
//   config    cfg_idx_i cfg_data_i                          cfg_we_i
//
// One transaction per cycle; busy stays low. The pipeline has nine
// stages up to the divider, 76 in the divider (an entry stage, then one
// quotient bit per stage over a 75-bit dividend) and nine after it.
// Reset clears the valid bits and the trim registers. The pipeline never
// stalls: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module thp_sensor_compensation import thp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [RAWT_W-1:0]    raw_temperature_i,
  input  wire logic [RAWP_W-1:0]    raw_pressure_i,
  input  wire logic [RAWH_W-1:0]    raw_humidity_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output logic                      done_o,
  output logic signed [TF_W-1:0]    fine_temperature_o,
  output logic signed [TC_W-1:0]    temperature_centi_o,
  output logic [PRESS_W-1:0]        pressure_q24_8_o,
  output logic [HUM_W-1:0]          humidity_q22_10_o,
  output logic                      pressure_divisor_zero_o
);

  localparam int POST_N = 8;

  // --------------------------------------------------------------------------
  // trim registers
  logic [47:0] temp_trim_q;
  logic [63:0] press_low_q, press_high_q;
  logic [47:0] press_hum_q;
  logic [39:0] hum_trim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q  <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_hum_q  <= '0;
      hum_trim_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP_TRIM:  temp_trim_q  <= cfg_data_i[47:0];
        CFG_PRESS_LOW:  press_low_q  <= cfg_data_i;
        CFG_PRESS_HIGH: press_high_q <= cfg_data_i;
        CFG_PRESS_HUM:  press_hum_q  <= cfg_data_i[47:0];
        CFG_HUM_TRIM:   hum_trim_q   <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  hum_cal_t           hcal;

  assign t1 = temp_trim_q[15:0];
  assign t2 = temp_trim_q[31:16];
  assign t3 = temp_trim_q[47:32];
  assign p1 = press_low_q[15:0];
  assign p2 = press_low_q[31:16];
  assign p3 = press_low_q[47:32];
  assign p4 = press_low_q[63:48];
  assign p5 = press_high_q[15:0];
  assign p6 = press_high_q[31:16];
  assign p7 = press_high_q[47:32];
  assign p8 = press_high_q[63:48];
  assign p9 = press_hum_q[15:0];
  assign hcal.h1 = press_hum_q[23:16];
  assign hcal.h2 = press_hum_q[39:24];
  assign hcal.h3 = press_hum_q[47:40];
  assign hcal.h4 = hum_trim_q[15:0];
  assign hcal.h5 = hum_trim_q[31:16];
  assign hcal.h6 = hum_trim_q[39:32];

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // valid chain up to the divider
  logic [9:1] pre_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
    end else begin
      pre_vld_q <= {pre_vld_q[8:1], start & ~busy};
    end
  end

  // stage 1: temperature products
  logic signed [16:0] s1_dt;
  logic signed [17:0] s1_xt;
  logic signed [33:0] s1_m1_d, s1_dd_full;
  logic signed [33:0] s1_m1_q;
  logic        [31:0] s1_dd_q;
  logic [RAWP_W-1:0]  s1_adcp_q;
  logic [RAWH_W-1:0]  s1_adch_q;

  always_comb begin
    s1_dt      = $signed({1'b0, raw_temperature_i[19:4]}) - $signed({1'b0, t1});
    s1_xt      = $signed({1'b0, raw_temperature_i[19:3]}) - $signed({1'b0, t1, 1'b0});
    s1_m1_d    = s1_xt * t2;
    s1_dd_full = s1_dt * s1_dt;
  end

  always_ff @(posedge clk_i) begin
    s1_m1_q   <= s1_m1_d;
    s1_dd_q   <= s1_dd_full[31:0];
    s1_adcp_q <= raw_pressure_i;
    s1_adch_q <= raw_humidity_i;
  end

  // stage 2: squared-term product
  logic signed [22:0] s2_m1s_q;
  logic signed [36:0] s2_t3p_q;
  logic [RAWP_W-1:0]  s2_adcp_q;
  logic [RAWH_W-1:0]  s2_adch_q;

  always_ff @(posedge clk_i) begin
    s2_m1s_q  <= s1_m1_q[33:11];
    s2_t3p_q  <= $signed({1'b0, s1_dd_q[31:12]}) * t3;
    s2_adcp_q <= s1_adcp_q;
    s2_adch_q <= s1_adch_q;
  end

  // stage 3: fine temperature
  logic signed [TF_W-1:0] s3_tf_q;
  logic [RAWP_W-1:0]      s3_adcp_q;
  logic [RAWH_W-1:0]      s3_adch_q;

  always_ff @(posedge clk_i) begin
    s3_tf_q   <= TF_W'(s2_m1s_q) + TF_W'($signed(s2_t3p_q[36:14]));
    s3_adcp_q <= s2_adcp_q;
    s3_adch_q <= s2_adch_q;
  end

  // stage 4: pressure offset products and centi-degree temperature
  logic signed [24:0] s4_e;
  logic signed [49:0] s4_ee_full;
  logic signed [26:0] s4_tf5;
  logic        [45:0] s4_ee_q;
  logic signed [40:0] s4_ep5_q, s4_ep2_q;
  logic [RAWP_W-1:0]  s4_adcp_q;
  side_t              s4_side_q;

  always_comb begin
    s4_e       = 25'(s3_tf_q) - 25'(PRESS_TF_OFS);
    s4_ee_full = s4_e * s4_e;
    s4_tf5     = (27'(s3_tf_q) <<< 2) + 27'(s3_tf_q) + 27'(TC_RND);
  end

  always_ff @(posedge clk_i) begin
    s4_ee_q         <= s4_ee_full[45:0];
    s4_ep5_q        <= s4_e * p5;
    s4_ep2_q        <= s4_e * p2;
    s4_adcp_q       <= s3_adcp_q;
    s4_side_q.tf    <= s3_tf_q;
    s4_side_q.tc    <= s4_tf5[26:8];
    s4_side_q.adc_h <= s3_adch_q;
    s4_side_q.dz    <= 1'b0;
  end

  // stage 5: square times P6 and P3, split in halves
  logic signed [39:0] s5_lop6_q, s5_hip6_q, s5_lop3_q, s5_hip3_q;
  logic signed [40:0] s5_ep5_q, s5_ep2_q;
  logic [RAWP_W-1:0]  s5_adcp_q;
  side_t              s5_side_q;

  always_ff @(posedge clk_i) begin
    s5_lop6_q <= $signed({1'b0, s4_ee_q[22:0]}) * p6;
    s5_hip6_q <= $signed({1'b0, s4_ee_q[45:23]}) * p6;
    s5_lop3_q <= $signed({1'b0, s4_ee_q[22:0]}) * p3;
    s5_hip3_q <= $signed({1'b0, s4_ee_q[45:23]}) * p3;
    s5_ep5_q  <= s4_ep5_q;
    s5_ep2_q  <= s4_ep2_q;
    s5_adcp_q <= s4_adcp_q;
    s5_side_q <= s4_side_q;
  end

  // stage 6: sum the two pressure polynomials
  logic signed [63:0] s6_q2_d, s6_eep3, s6_q1_full;
  logic signed [55:0] s6_q1_q;
  logic signed [63:0] s6_q2_q;
  logic [RAWP_W-1:0]  s6_adcp_q;
  side_t              s6_side_q;

  always_comb begin
    s6_q2_d    = (64'(s5_hip6_q) <<< 23) + 64'(s5_lop6_q)
               + (64'(s5_ep5_q) <<< 17) + (64'(p4) <<< 35);
    s6_eep3    = (64'(s5_hip3_q) <<< 23) + 64'(s5_lop3_q);
    s6_q1_full = (s6_eep3 >>> 8) + (64'(s5_ep2_q) <<< 12);
  end

  always_ff @(posedge clk_i) begin
    s6_q1_q   <= s6_q1_full[55:0];
    s6_q2_q   <= s6_q2_d;
    s6_adcp_q <= s5_adcp_q;
    s6_side_q <= s5_side_q;
  end

  // stage 7: divisor product halves and dividend base
  logic signed [56:0] s7_a;
  logic        [20:0] s7_pdiff;
  logic        [44:0] s7_pdlo_q;
  logic signed [44:0] s7_pdhi_q;
  logic signed [63:0] s7_nb_q;
  side_t              s7_side_q;

  always_comb begin
    s7_a     = 57'(s6_q1_q) + 57'(DEN_BIAS);
    s7_pdiff = 21'(PDIFF_BASE) - {1'b0, s6_adcp_q};
  end

  always_ff @(posedge clk_i) begin
    s7_pdlo_q <= s7_a[28:0] * p1;
    s7_pdhi_q <= $signed(s7_a[56:29]) * $signed({1'b0, p1});
    s7_nb_q   <= $signed({12'b0, s7_pdiff, 31'b0}) - s6_q2_q;
    s7_side_q <= s6_side_q;
  end

  // stage 8: divisor, dividend scale products
  logic signed [73:0]      s8_den_full;
  logic signed [DEN_W-1:0] s8_den_q;
  logic        [43:0]      s8_lo3_q;
  logic signed [44:0]      s8_hi3_q;
  side_t                   s8_side_q;

  always_comb begin
    s8_den_full = (74'(s7_pdhi_q) <<< 29) + $signed({29'b0, s7_pdlo_q});
  end

  always_ff @(posedge clk_i) begin
    s8_den_q  <= s8_den_full[72:33];
    s8_lo3_q  <= s7_nb_q[31:0] * 12'(NUM_SCALE);
    s8_hi3_q  <= $signed(s7_nb_q[63:32]) * $signed(13'(NUM_SCALE));
    s8_side_q <= s7_side_q;
  end

  // stage 9: dividend, zero-divisor flag
  logic signed [76:0]      s9_num_full;
  logic signed [NUM_W-1:0] s9_num_q;
  logic signed [DEN_W-1:0] s9_den_q;
  side_t                   s9_side_q;

  always_comb begin
    s9_num_full = (77'(s8_hi3_q) <<< 32) + $signed({33'b0, s8_lo3_q});
  end

  always_ff @(posedge clk_i) begin
    s9_num_q        <= s9_num_full[NUM_W-1:0];
    s9_den_q        <= s8_den_q;
    s9_side_q.tf    <= s8_side_q.tf;
    s9_side_q.tc    <= s8_side_q.tc;
    s9_side_q.adc_h <= s8_side_q.adc_h;
    s9_side_q.dz    <= (s8_den_q == '0);
  end

  // --------------------------------------------------------------------------
  // divider
  logic              dv_vld;
  logic [NMAG_W-1:0] dv_mag;
  logic              dv_neg;
  side_t             dv_side;

  thp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (pre_vld_q[9]),
    .num_i     (s9_num_q),
    .den_i     (s9_den_q),
    .side_i    (s9_side_q),
    .out_vld_o (dv_vld),
    .quo_mag_o (dv_mag),
    .quo_neg_o (dv_neg),
    .side_o    (dv_side)
  );

  // humidity runs beside the pressure post-processing, same depth
  logic [HUM_W-1:0] hum;

  thp_hum u_hum (
    .clk_i   (clk_i),
    .tf_i    (dv_side.tf),
    .adc_h_i (dv_side.adc_h),
    .cal_i   (hcal),
    .hum_o   (hum)
  );

  // --------------------------------------------------------------------------
  // post-division valid and sideband shift line
  logic [POST_N:1] post_vld_q;
  side_t           post_side_q [POST_N+1];

  assign post_side_q[0] = dv_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_vld_q <= '0;
    end else begin
      post_vld_q <= {post_vld_q[POST_N-1:1], dv_vld};
    end
  end

  for (genvar j = 1; j <= POST_N; j++) begin : g_side
    always_ff @(posedge clk_i) begin
      post_side_q[j] <= post_side_q[j-1];
    end
  end

  // q1: signed quotient
  logic signed [NUM_W-1:0] q1_p_q;

  always_ff @(posedge clk_i) begin
    q1_p_q <= dv_neg ? -$signed({1'b0, dv_mag}) : $signed({1'b0, dv_mag});
  end

  // q2: magnitude of p / 2^13, P8 * p in three chunks
  logic signed [62:0]      q2_h, q2_hneg;
  logic        [61:0]      q2_habs_q;
  logic signed [42:0]      q2_pp0_q, q2_pp1_q;
  logic signed [39:0]      q2_pp2_q;
  logic signed [NUM_W-1:0] q2_p_q;

  always_comb begin
    q2_h    = q1_p_q[75:13];
    q2_hneg = -q2_h;
  end

  always_ff @(posedge clk_i) begin
    q2_habs_q <= q2_h[62] ? q2_hneg[61:0] : q2_h[61:0];
    q2_pp0_q  <= $signed({1'b0, q1_p_q[25:0]}) * p8;
    q2_pp1_q  <= $signed({1'b0, q1_p_q[51:26]}) * p8;
    q2_pp2_q  <= $signed(q1_p_q[75:52]) * p8;
    q2_p_q    <= q1_p_q;
  end

  // q3: square partial products, P8 term
  logic signed [91:0]      q3_t2_full;
  logic        [61:0]      q3_ll_q, q3_lh_q, q3_hh_q;
  logic signed [72:0]      q3_t2_q;
  logic signed [NUM_W-1:0] q3_p_q;

  always_comb begin
    q3_t2_full = (92'(q2_pp2_q) <<< 52) + (92'(q2_pp1_q) <<< 26) + 92'(q2_pp0_q);
  end

  always_ff @(posedge clk_i) begin
    q3_ll_q <= q2_habs_q[30:0] * q2_habs_q[30:0];
    q3_lh_q <= q2_habs_q[30:0] * q2_habs_q[61:31];
    q3_hh_q <= q2_habs_q[61:31] * q2_habs_q[61:31];
    q3_t2_q <= q3_t2_full[91:19];
    q3_p_q  <= q2_p_q;
  end

  // q4: full square
  logic        [123:0]     q4_sq_full;
  logic        [122:0]     q4_sq_q;
  logic signed [72:0]      q4_t2_q;
  logic signed [NUM_W-1:0] q4_p_q;

  always_comb begin
    q4_sq_full = (124'(q3_hh_q) << 62) + (124'(q3_lh_q) << 32) + 124'(q3_ll_q);
  end

  always_ff @(posedge clk_i) begin
    q4_sq_q <= q4_sq_full[122:0];
    q4_t2_q <= q3_t2_q;
    q4_p_q  <= q3_p_q;
  end

  // q5: P9 times the square in 32-bit chunks
  logic signed [48:0]      q5_m0_q, q5_m1_q, q5_m2_q;
  logic signed [43:0]      q5_m3_q;
  logic signed [72:0]      q5_t2_q;
  logic signed [NUM_W-1:0] q5_p_q;

  always_ff @(posedge clk_i) begin
    q5_m0_q <= $signed({1'b0, q4_sq_q[31:0]}) * p9;
    q5_m1_q <= $signed({1'b0, q4_sq_q[63:32]}) * p9;
    q5_m2_q <= $signed({1'b0, q4_sq_q[95:64]}) * p9;
    q5_m3_q <= $signed({1'b0, q4_sq_q[122:96]}) * p9;
    q5_t2_q <= q4_t2_q;
    q5_p_q  <= q4_p_q;
  end

  // q6: P9 term
  logic signed [139:0]     q6_t1_full;
  logic signed [114:0]     q6_t1_q;
  logic signed [72:0]      q6_t2_q;
  logic signed [NUM_W-1:0] q6_p_q;

  always_comb begin
    q6_t1_full = (140'(q5_m3_q) <<< 96) + (140'(q5_m2_q) <<< 64)
               + (140'(q5_m1_q) <<< 32) + 140'(q5_m0_q);
  end

  always_ff @(posedge clk_i) begin
    q6_t1_q <= q6_t1_full[139:25];
    q6_t2_q <= q5_t2_q;
    q6_p_q  <= q5_p_q;
  end

  // q7: p + t1 + t2
  logic signed [115:0] q7_s_q;

  always_ff @(posedge clk_i) begin
    q7_s_q <= 116'(q6_p_q) + 116'(q6_t1_q) + 116'(q6_t2_q);
  end

  // q8: scale and P7 offset
  logic signed [108:0] q8_r_q;

  always_ff @(posedge clk_i) begin
    q8_r_q <= 109'($signed(q7_s_q[115:8])) + (109'(p7) <<< 4);
  end

  // --------------------------------------------------------------------------
  // output register: saturate pressure
  logic [PRESS_W-1:0] press_d;
  side_t              out_side;

  assign out_side = post_side_q[POST_N];

  always_comb begin
    if (out_side.dz || q8_r_q[108]) begin
      press_d = '0;
    end else if (|q8_r_q[107:PRESS_W]) begin
      press_d = '1;
    end else begin
      press_d = q8_r_q[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= post_vld_q[POST_N];
    end
  end

  always_ff @(posedge clk_i) begin
    fine_temperature_o      <= out_side.tf;
    temperature_centi_o     <= out_side.tc;
    pressure_q24_8_o        <= press_d;
    humidity_q22_10_o       <= hum;
    pressure_divisor_zero_o <= out_side.dz;
  end

endmodule
`default_nettype wire
